// ----- sv/quantum_inspired_probability_search_defines.svh -----
// Assertion macros for the quantum-inspired probability search block.
`ifndef QUANTUM_INSPIRED_PROBABILITY_SEARCH_DEFINES_SVH
`define QUANTUM_INSPIRED_PROBABILITY_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS
// Checked while out of reset.
`define QIPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define QIPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QIPS_ASSERT(lbl, prop, msg)
`define QIPS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- sv/qips_pkg.sv -----
// Shared types, constants and functions of the probability search core.
package qips_pkg;

  localparam int MAX_STOCKS = 64;
  localparam int PARTICLES  = 10;
  localparam int IDX_W      = $clog2(MAX_STOCKS);
  localparam int CNT_W      = $clog2(MAX_STOCKS + 1);

  localparam logic [16:0] PROB_ONE  = 17'd65536;
  localparam logic [16:0] PROB_HALF = 17'd32768;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  localparam logic [15:0] THETA_RST = 16'd26;
  localparam logic [6:0]  COUNT_RST = 7'd64;
  localparam logic [15:0] SEED_RST  = 16'd44257;

  localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] SCORE_MAX = 32'sh7FFF_FFFF;

  // input word modes
  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_EVAL   = 2'd1;
  localparam logic [1:0] MODE_UPDATE = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  // config register indexes
  localparam logic [1:0] REG_THETA = 2'd0;
  localparam logic [1:0] REG_COUNT = 2'd1;
  localparam logic [1:0] REG_SEED  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_WALK,
    ST_EMIT
  } state_t;

  // Galois LFSR, shift right
  function automatic logic [15:0] lfsr_step(input logic [15:0] r);
    logic [15:0] s;
    begin
      s = r >> 1;
      if (r[0]) s = s ^ LFSR_TAPS;
      return s;
    end
  endfunction

  // zero seed would lock the LFSR
  function automatic logic [15:0] seed_fix(input logic [15:0] s);
    return (s == 16'd0) ? 16'd1 : s;
  endfunction

  // one probability step toward the best vector
  function automatic logic [16:0] prob_step(input logic [16:0] p,
                                            input logic [15:0] theta,
                                            input logic b,
                                            input logic w);
    logic [16:0] m;
    logic [17:0] sum;
    begin
      m = p;
      sum = 18'd0;
      if (!b && w) begin
        if (p > PROB_HALF) m = PROB_ONE - p;
        m = (m > {1'b0, theta}) ? (m - {1'b0, theta}) : 17'd0;
      end else if (b && !w) begin
        if (p < PROB_HALF) m = PROB_ONE - p;
        sum = {1'b0, m} + {2'b00, theta};
        m = (sum > {1'b0, PROB_ONE}) ? PROB_ONE : sum[16:0];
      end
      return m;
    end
  endfunction

endpackage

// ----- sv/quantum_inspired_probability_search.sv -----
// Top level of the quantum-inspired probability search core.
// Each input word carries a mode and a fitness and yields exactly one output
// word showing the state after that word. Sample (mode 0) and update (mode 2)
// walk the select-probability memory one stock per cycle, read through a
// register ahead of the shared sample/step unit, and then load the output
// register. Evaluate (mode 1) passes through an evaluate state before its
// output word is loaded, while read best (mode 3) loads it directly. The
// block takes no new word while one is in work, but a finished word parks
// in the output register, so the next word is accepted while the previous
// output still waits. The probability memory has one valid flag per entry,
// cleared by reset, so an entry never written reads as one half and no
// clearing pass is needed.
// Config writes are accepted on every cycle; they are meant for idle time.
// Writing lfsr_seed also reloads the generator; a zero seed loads as 1.
`include "quantum_inspired_probability_search_defines.svh"

module quantum_inspired_probability_search
  import qips_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // config write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  // input words
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          mode,
  input  logic signed [31:0]  fitness,
  // output words
  output logic                out_valid,
  input  logic                out_ready,
  output logic [63:0]         candidate,
  output logic [63:0]         best_solution,
  output logic signed [31:0]  best_fitness,
  output logic [15:0]         best_generation,
  output logic [7:0]          best_particle
);

  // config registers
  logic [15:0] theta;
  logic [6:0]  stock_count;

  // search state
  logic [MAX_STOCKS-1:0] best_vector;
  logic signed [31:0]    best_score;
  logic [MAX_STOCKS-1:0] worst_vector;
  logic signed [31:0]    worst_score;
  logic [MAX_STOCKS-1:0] last_candidate;
  logic [15:0]           rng;
  logic [15:0]           generation_count;
  logic [7:0]            particle_index;
  logic [15:0]           best_gen_reg;
  logic [7:0]            best_part_reg;

  // probability memory with per-entry valid flags
  logic [16:0]           prob_mem [MAX_STOCKS];
  logic [MAX_STOCKS-1:0] prob_vld;
  logic [16:0]           prob_q;
  logic                  prob_q_vld;

  // sequencer
  state_t           state, state_next;
  logic [1:0]       mode_q;
  logic signed [31:0] fit_q;
  logic [CNT_W-1:0] rd_cnt;        // next entry to read
  logic             pv;            // processing stage holds an entry
  logic [IDX_W-1:0] pidx;          // entry in processing stage

  logic [CNT_W-1:0] n_act;
  logic             cfg_we;
  logic             in_acc;
  logic             issue;
  logic             last_proc;
  logic             load_out;
  logic [16:0]      p_cur;
  logic [15:0]      rng_draw;
  logic [16:0]      p_new;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign in_acc    = in_valid & in_ready;

  // stock count clamped to 1..MAX_STOCKS
  always_comb begin
    if (stock_count == 7'd0) n_act = CNT_W'(1);
    else if (stock_count > 7'(MAX_STOCKS)) n_act = CNT_W'(MAX_STOCKS);
    else n_act = CNT_W'(stock_count);
  end

  assign last_proc = pv && ({1'b0, pidx} == (n_act - CNT_W'(1)));

  // shared unit: one draw or one probability step per cycle
  assign p_cur    = prob_q_vld ? prob_q : PROB_HALF;
  assign rng_draw = lfsr_step(rng);
  assign p_new    = prob_step(p_cur, theta, best_vector[pidx], worst_vector[pidx]);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (mode == MODE_SAMPLE || mode == MODE_UPDATE) state_next = ST_WALK;
          else if (mode == MODE_EVAL) state_next = ST_EVAL;
          else state_next = ST_EMIT;
        end
      end
      ST_EVAL: state_next = ST_EMIT;
      ST_WALK: begin
        if (last_proc) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_EVAL: ;
      ST_WALK: issue = (rd_cnt < n_act);
      ST_EMIT: load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // input capture and walk counters
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt <= '0;
      pv     <= 1'b0;
      pidx   <= '0;
    end else begin
      if (in_acc) rd_cnt <= '0;
      else if (issue) rd_cnt <= rd_cnt + CNT_W'(1);
      pv   <= issue;
      pidx <= rd_cnt[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_q <= mode;
      fit_q  <= fitness;
    end
  end

  // probability memory: registered read, write from the update step
  always_ff @(posedge clk) begin
    prob_q <= prob_mem[rd_cnt[IDX_W-1:0]];
    if (pv && mode_q == MODE_UPDATE) prob_mem[pidx] <= p_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prob_vld   <= '0;
      prob_q_vld <= 1'b0;
    end else begin
      prob_q_vld <= prob_vld[rd_cnt[IDX_W-1:0]];
      if (pv && mode_q == MODE_UPDATE) prob_vld[pidx] <= 1'b1;
    end
  end

  // config registers and search state
  always_ff @(posedge clk) begin
    if (rst) begin
      theta            <= THETA_RST;
      stock_count      <= COUNT_RST;
      rng              <= seed_fix(SEED_RST);
      best_vector      <= '0;
      best_score       <= SCORE_MIN;
      worst_vector     <= '0;
      worst_score      <= SCORE_MAX;
      last_candidate   <= '0;
      generation_count <= '0;
      particle_index   <= '0;
      best_gen_reg     <= '0;
      best_part_reg    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_THETA: theta <= cfg_data;
          REG_COUNT: stock_count <= cfg_data[6:0];
          REG_SEED: begin
            rng <= seed_fix(cfg_data);
          end
          default: ;
        endcase
      end

      // sample clears the old candidate, bits fill in as the walk goes
      if (in_acc && mode == MODE_SAMPLE) last_candidate <= '0;

      if (pv && mode_q == MODE_SAMPLE) begin
        rng <= rng_draw;
        last_candidate[pidx] <= ({1'b0, rng_draw} < p_cur);
      end

      if (last_proc && mode_q == MODE_UPDATE) begin
        generation_count <= generation_count + 16'd1;
        particle_index   <= '0;
        worst_score      <= SCORE_MAX;
      end

      if (state == ST_EVAL) begin
        if (best_score < fit_q) begin
          if (fit_q < 0) begin
            best_score  <= '0;
            best_vector <= '0;
          end else begin
            best_score  <= fit_q;
            best_vector <= last_candidate;
          end
          best_gen_reg  <= generation_count;
          best_part_reg <= particle_index;
        end
        if (worst_score > fit_q) begin
          worst_score  <= fit_q;
          worst_vector <= last_candidate;
        end
        if (particle_index == 8'(PARTICLES - 1)) particle_index <= '0;
        else particle_index <= particle_index + 8'd1;
      end
    end
  end

  // output register, parts the two sides
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      candidate       <= last_candidate;
      best_solution   <= best_vector;
      best_fitness    <= best_score;
      best_generation <= best_gen_reg;
      best_particle   <= best_part_reg;
    end
  end

  `QIPS_ASSERT(a_pidx_range, pv |-> ({1'b0, pidx} < n_act), "walk index beyond stock count")
  `QIPS_ASSERT(a_rd_bound, (state == ST_WALK) |-> (rd_cnt <= n_act), "read counter overran")
  `QIPS_ASSERT(a_rng_nonzero, rng != 16'd0, "LFSR locked at zero")
  `QIPS_ASSERT(a_busy_after_accept, in_acc |=> !in_ready, "accepted a word while busy")
  `QIPS_ASSERT(a_proc_in_walk, pv |-> (state == ST_WALK), "processing outside a walk")

endmodule
